>>> rtl/core/cbsp_pkg.sv
// Shared constants and controller command type for the cubic B-spline evaluator.
package cbsp_pkg;

  // Default coordinate width and fraction bits of the curve parameter
  localparam int COORD_BITS_DEF  = 10;
  localparam int T_FRAC_BITS_DEF = 16;

  // Control points held in the sliding window
  localparam int WIN_DEPTH = 4;
  localparam int WIN_SEL_W = $clog2(WIN_DEPTH);

  // Fraction bits of the result
  localparam int OUT_FRAC_BITS = 8;

  // Command word from the controller to the datapath
  typedef struct packed {
    logic                 push;      // shift a new point into the window
    logic                 load_t;    // capture and clamp t
    logic                 sq;        // t^2 on the shared multiplier
    logic                 cube;      // t^3 on the shared multiplier
    logic                 wgt;       // register the four basis weights
    logic                 mac;       // one multiply-accumulate step per lane
    logic                 mac_first; // start a fresh sum
    logic [WIN_SEL_W-1:0] mac_sel;   // window entry and weight for this step
    logic                 div;       // scale by the reciprocal of six
    logic                 fin;       // correct, saturate, load result register
  } cmd_t;

endpackage

>>> rtl/core/cubic_bspline_point_eval.sv
// Top level of the uniform cubic B-spline point evaluator.
//
// Input channel in_*: one request per command. in_tuser = 0 pushes the point
// in in_tdata into a four-point window and gives no result; in_tuser = 1
// evaluates the curve at the t in in_tdata. An evaluate before four points
// have been pushed is consumed without starting a sequence and gives no result.
// Output channel out_*: one request per evaluate, X and Y with 8 fraction bits.
// Push requests can be accepted on every cycle while no evaluate is in progress.
// An evaluate keeps the input closed after it is accepted, through its steps:
// t^2 and t^3 on the shared multiplier, the weight register, four
// multiply-accumulate steps, one per window point, in each lane, reciprocal
// scaling and the final correction. Its result shows on out_tvalid and the
// input reopens in the same cycle, so no new request is taken while an
// evaluate is still in progress.
// The output register holds a finished result while the receiver stalls;
// pushes are still accepted meanwhile, and a later evaluate waits in its
// last step until the output register frees up.
// Reset (rst_n low, synchronous) empties the window count, the sequencer and
// the output register; the window contents stay undefined until pushed.
module cubic_bspline_point_eval #(
  parameter int  COORD_BITS  = cbsp_pkg::COORD_BITS_DEF,
  parameter int  T_FRAC_BITS = cbsp_pkg::T_FRAC_BITS_DEF,
  localparam int OW          = COORD_BITS + cbsp_pkg::OUT_FRAC_BITS,
  localparam int IN_W        = ((2 * COORD_BITS + T_FRAC_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_W       = ((2 * OW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // point_x, point_y, param_t, zero pad
  input  logic             in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // curve_x, curve_y, zero pad
);

  localparam int PY_LO = COORD_BITS;
  localparam int PT_LO = 2 * COORD_BITS;

  cbsp_pkg::cmd_t  cmd;
  logic [OW-1:0]   curve_x;
  logic [OW-1:0]   curve_y;

  cbsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cbsp_datapath #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_point_x  (in_tdata[COORD_BITS-1:0]),
    .in_point_y  (in_tdata[PY_LO+COORD_BITS-1:PY_LO]),
    .in_param_t  (in_tdata[PT_LO+T_FRAC_BITS:PT_LO]),
    .out_curve_x (curve_x),
    .out_curve_y (curve_y)
  );

  // Pack the result, zero padded to whole bytes
  assign out_tdata = OUT_W'({curve_y, curve_x});

`ifndef NO_ASSERTIONS
  // The result register is loaded only when its previous result is gone
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_tvalid || out_tready))
    else $error("result register overwritten while still pending");

  // Only one datapath step is commanded in a cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.load_t, cmd.sq, cmd.cube, cmd.wgt, cmd.mac,
              cmd.div, cmd.fin}))
    else $error("more than one datapath step commanded");

  // An evaluate closes the input until its result is produced
  a_eval_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_t |=> !in_tready)
    else $error("input reopened during an evaluate");

  // A finished result shows as valid on the next cycle
  a_fin_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid)
    else $error("finished result not presented");
`endif

endmodule

>>> rtl/core/cbsp_ctrl.sv
// Sequencing state machine: point counter, evaluate steps and result valid.
module cbsp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  output cbsp_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_CUBE = 7'b0000100,
    S_WGT  = 7'b0001000,
    S_MAC  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  localparam int CNT_W = $clog2(cbsp_pkg::WIN_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cbsp_pkg::WIN_DEPTH);
  localparam logic [cbsp_pkg::WIN_SEL_W-1:0] MAC_LAST =
    cbsp_pkg::WIN_SEL_W'(cbsp_pkg::WIN_DEPTH - 1);

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               loaded_r, loaded_nxt;
  logic [cbsp_pkg::WIN_SEL_W-1:0] mac_cnt_r, mac_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    mac_cnt_nxt   = mac_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mac_sel   = mac_cnt_r;

    // Drop the result once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_tuser) begin
            cmd.push = 1'b1;
            if (loaded_r != CNT_FULL) begin
              loaded_nxt = loaded_r + CNT_W'(1);
            end
          end else if (loaded_r == CNT_FULL) begin
            cmd.load_t = 1'b1;
            state_nxt  = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        state_nxt = S_WGT;
      end
      S_WGT: begin
        cmd.wgt     = 1'b1;
        mac_cnt_nxt = '0;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mac       = 1'b1;
        cmd.mac_first = (mac_cnt_r == '0);
        mac_cnt_nxt   = mac_cnt_r + cbsp_pkg::WIN_SEL_W'(1);
        if (mac_cnt_r == MAC_LAST) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free or being emptied
        if (!out_valid_r || out_tready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      mac_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      mac_cnt_r   <= mac_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/cbsp_lane.sv
// One coordinate lane: weighted sum, divide by six with rounding, saturation.
module cbsp_lane #(
  parameter int COORD_BITS  = cbsp_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbsp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  cbsp_pkg::cmd_t                                 cmd,
  input  logic signed [T_FRAC_BITS+3:0]                  weight,
  input  logic [COORD_BITS-1:0]                          point,
  output logic [COORD_BITS+cbsp_pkg::OUT_FRAC_BITS-1:0]  result
);

  localparam int WW  = T_FRAC_BITS + 4;
  localparam int PRW = WW + COORD_BITS + 1;
  localparam int AW  = WW + COORD_BITS + 3;
  localparam int SW  = AW + cbsp_pkg::OUT_FRAC_BITS;
  localparam int QW  = SW - T_FRAC_BITS;
  localparam int XW  = QW - 1;
  localparam int OW  = COORD_BITS + cbsp_pkg::OUT_FRAC_BITS;

  // Half of the divisor six times one, for round half up
  localparam logic [SW-1:0] RND_SIX = SW'(3) << T_FRAC_BITS;
  // Truncated reciprocal of three; the quotient is low by at most one
  localparam logic [XW-1:0] Recip3 = XW'((64'd1 << XW) / 64'd3);

  logic signed [PRW-1:0] prod;
  logic signed [AW-1:0]  prod_ext;
  logic signed [AW-1:0]  acc_r;
  logic [SW-1:0]         qsum;
  logic [QW-1:0]         quo6;
  logic [XW-1:0]         half_q;
  logic [2*XW-1:0]       recip_prod;
  logic [XW-1:0]         x_r;
  logic [XW-1:0]         q_r;
  logic                  pos_r;
  logic [XW:0]           q3;
  logic [XW:0]           rem;
  logic [XW-1:0]         q_fix;
  logic [OW-1:0]         q_sat;
  logic [OW-1:0]         res_r;

  // Multiply-accumulate
  assign prod     = weight * $signed({1'b0, point});
  assign prod_ext = $signed({{(AW-PRW){prod[PRW-1]}}, prod});

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      acc_r <= cmd.mac_first ? prod_ext : acc_r + prod_ext;
    end
  end

  // Scale: floor((S*256 + 3*one) / one) then divide by six as halve and by three
  assign qsum   = {acc_r, {cbsp_pkg::OUT_FRAC_BITS{1'b0}}} + RND_SIX;
  assign quo6   = qsum[SW-1:T_FRAC_BITS];
  assign half_q = quo6[QW-1:1];
  assign recip_prod = half_q * Recip3;

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      x_r   <= half_q;
      q_r   <= recip_prod[2*XW-1:XW];
      pos_r <= !acc_r[AW-1] && (acc_r != '0);
    end
  end

  // Correct the quotient by one where the remainder reaches three
  assign q3    = {q_r, 1'b0} + {1'b0, q_r};
  assign rem   = {1'b0, x_r} - q3;
  assign q_fix = (rem >= (XW+1)'(3)) ? q_r + XW'(1) : q_r;
  assign q_sat = (|q_fix[XW-1:OW]) ? {OW{1'b1}} : q_fix[OW-1:0];

  // Result register; a sum at or below zero gives zero
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_r <= pos_r ? q_sat : '0;
    end
  end

  assign result = res_r;

endmodule

>>> rtl/core/cbsp_datapath.sv
// Datapath: point window, t powers on a shared multiplier, weights, two lanes.
module cbsp_datapath #(
  parameter int COORD_BITS  = cbsp_pkg::COORD_BITS_DEF,
  parameter int T_FRAC_BITS = cbsp_pkg::T_FRAC_BITS_DEF
) (
  input  logic                                           clk,
  input  cbsp_pkg::cmd_t                                 cmd,
  input  logic [COORD_BITS-1:0]                          in_point_x,
  input  logic [COORD_BITS-1:0]                          in_point_y,
  input  logic [T_FRAC_BITS:0]                           in_param_t,
  output logic [COORD_BITS+cbsp_pkg::OUT_FRAC_BITS-1:0]  out_curve_x,
  output logic [COORD_BITS+cbsp_pkg::OUT_FRAC_BITS-1:0]  out_curve_y
);

  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = 2 * TW;
  localparam int WW = T_FRAC_BITS + 4;
  localparam int ND = cbsp_pkg::WIN_DEPTH;

  localparam logic [TW-1:0] T_ONE    = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] RND_HALF = PW'(1) << (T_FRAC_BITS - 1);

  logic [COORD_BITS-1:0] win_x_r [ND];
  logic [COORD_BITS-1:0] win_y_r [ND];
  logic [TW-1:0]         t_clamp;
  logic [TW-1:0]         t_r;
  logic [TW-1:0]         t2_r;
  logic [TW-1:0]         t3_r;
  logic [TW-1:0]         sq_b;
  logic [PW-1:0]         sq_prod;
  logic [PW-1:0]         sq_sum;
  logic [TW-1:0]         sq_rnd;
  logic signed [WW-1:0]  one_s, ts, t2s, t3s;
  logic signed [WW-1:0]  w_nxt [ND];
  logic signed [WW-1:0]  w_r   [ND];

  // Shift the window on a push
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int i = 0; i < ND - 1; i++) begin
        win_x_r[i] <= win_x_r[i+1];
        win_y_r[i] <= win_y_r[i+1];
      end
      win_x_r[ND-1] <= in_point_x;
      win_y_r[ND-1] <= in_point_y;
    end
  end

  // Clamp t to one
  assign t_clamp = (in_param_t > T_ONE) ? T_ONE : in_param_t;

  // Shared multiplier: t*t, then t^2*t, each rounded to nearest
  assign sq_b    = cmd.cube ? t2_r : t_r;
  assign sq_prod = t_r * sq_b;
  assign sq_sum  = sq_prod + RND_HALF;
  assign sq_rnd  = sq_sum[T_FRAC_BITS+TW-1:T_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.load_t) begin
      t_r <= t_clamp;
    end
    if (cmd.sq) begin
      t2_r <= sq_rnd;
    end
    if (cmd.cube) begin
      t3_r <= sq_rnd;
    end
  end

  // Six times each basis weight
  assign one_s = $signed({3'b000, T_ONE});
  assign ts    = $signed({3'b000, t_r});
  assign t2s   = $signed({3'b000, t2_r});
  assign t3s   = $signed({3'b000, t3_r});

  always_comb begin
    w_nxt[0] = one_s - (ts <<< 1) - ts + (t2s <<< 1) + t2s - t3s;
    w_nxt[1] = (one_s <<< 2) - (t2s <<< 2) - (t2s <<< 1) + (t3s <<< 1) + t3s;
    w_nxt[2] = one_s + (ts <<< 1) + ts + (t2s <<< 1) + t2s - (t3s <<< 1) - t3s;
    w_nxt[3] = t3s;
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt) begin
      for (int i = 0; i < ND; i++) begin
        w_r[i] <= w_nxt[i];
      end
    end
  end

  // Coordinate lanes
  cbsp_lane #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_x (
    .clk    (clk),
    .cmd    (cmd),
    .weight (w_r[cmd.mac_sel]),
    .point  (win_x_r[cmd.mac_sel]),
    .result (out_curve_x)
  );

  cbsp_lane #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lane_y (
    .clk    (clk),
    .cmd    (cmd),
    .weight (w_r[cmd.mac_sel]),
    .point  (win_y_r[cmd.mac_sel]),
    .result (out_curve_y)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the cubic B-spline point evaluator.
module tb_top;

  localparam int CW     = cbsp_pkg::COORD_BITS_DEF;
  localparam int TW     = cbsp_pkg::T_FRAC_BITS_DEF + 1;
  localparam int OW     = CW + cbsp_pkg::OUT_FRAC_BITS;
  localparam int IN_W   = ((2 * CW + TW + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * OW + 7) / 8) * 8;
  localparam longint T_ONE   = longint'(1) << cbsp_pkg::T_FRAC_BITS_DEF;
  localparam longint OUT_MAX = (longint'(1) << OW) - 1;
  localparam int CMAX   = (1 << CW) - 1;
  localparam int TMAX   = (1 << TW) - 1;

  // Command codes carried on in_tuser
  localparam bit CMD_PUSH = 1'b0;
  localparam bit CMD_EVAL = 1'b1;

  typedef struct {
    bit          cmd;
    bit [CW-1:0] px;
    bit [CW-1:0] py;
    bit [TW-1:0] pt;
    int          idle_pct;
    int          stall_pct;
  } bsp_req_t;

  typedef struct {
    logic [OW-1:0] cx;
    logic [OW-1:0] cy;
  } curve_pt_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  cubic_bspline_point_eval u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bsp_req_t  req_pending[$];
  curve_pt_t curve_expected[$];
  bsp_req_t  req_cur;
  int        req_total = 0;
  int        req_taken = 0;
  int        mismatches = 0;
  int        stall_pct = 0;
  int        ph_idle = 0;
  int        ph_stall = 0;

  // Predictor state: control point window and fill count
  logic [CW-1:0] win_x[4];
  logic [CW-1:0] win_y[4];
  int            pts_loaded = 0;

  // Weighted sum of one coordinate lane, rounded and saturated
  function automatic logic [OW-1:0] blend_lane(longint w[4], logic [CW-1:0] p[4]);
    longint s;
    longint r;
    s = 0;
    for (int j = 0; j < 4; j++) s += w[j] * longint'(p[j]);
    if (s <= 0) return '0;
    r = (s * 256 + 3 * T_ONE) / (6 * T_ONE);
    if (r > OUT_MAX) r = OUT_MAX;
    return r[OW-1:0];
  endfunction

  // Advance the predictor by one accepted request
  task automatic predict_curve(input bsp_req_t rq);
    longint    t;
    longint    t2;
    longint    t3;
    longint    w[4];
    curve_pt_t pt;
    if (rq.cmd == CMD_PUSH) begin
      for (int i = 0; i < 3; i++) begin
        win_x[i] = win_x[i+1];
        win_y[i] = win_y[i+1];
      end
      win_x[3] = rq.px;
      win_y[3] = rq.py;
      if (pts_loaded < 4) pts_loaded++;
      return;
    end
    // Drop evaluates until the window is full
    if (pts_loaded < 4) return;
    t = longint'(rq.pt);
    if (t > T_ONE) t = T_ONE;
    t2 = (t * t + T_ONE / 2) >> cbsp_pkg::T_FRAC_BITS_DEF;
    t3 = (t2 * t + T_ONE / 2) >> cbsp_pkg::T_FRAC_BITS_DEF;
    w[0] = T_ONE - 3 * t + 3 * t2 - t3;
    w[1] = 4 * T_ONE - 6 * t2 + 3 * t3;
    w[2] = T_ONE + 3 * t + 3 * t2 - 3 * t3;
    w[3] = t3;
    pt.cx = blend_lane(w, win_x);
    pt.cy = blend_lane(w, win_y);
    curve_expected.push_back(pt);
  endtask

  task automatic add_push(input int x, input int y);
    bsp_req_t rq;
    rq.cmd = CMD_PUSH;
    rq.px = x[CW-1:0];
    rq.py = y[CW-1:0];
    rq.pt = TW'($urandom_range(TMAX));
    rq.idle_pct = ph_idle;
    rq.stall_pct = ph_stall;
    req_pending.push_back(rq);
    req_total++;
  endtask

  task automatic add_eval(input int t);
    bsp_req_t rq;
    rq.cmd = CMD_EVAL;
    rq.px = CW'($urandom_range(CMAX));
    rq.py = CW'($urandom_range(CMAX));
    rq.pt = t[TW-1:0];
    rq.idle_pct = ph_idle;
    rq.stall_pct = ph_stall;
    req_pending.push_back(rq);
    req_total++;
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return CMAX;
    return $urandom_range(CMAX);
  endfunction

  function automatic int rand_t();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return int'(T_ONE);
    if (r < 20) return $urandom_range(TMAX, int'(T_ONE) + 1);
    if (r < 30) return $urandom_range(255);
    return $urandom_range(int'(T_ONE));
  endfunction

  // Driver: present queued requests, feed the predictor on each handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_curve(req_cur);
        req_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_pending.size() > 0 &&
            $urandom_range(99) >= req_pending[0].idle_pct) begin
          req_cur = req_pending.pop_front();
          stall_pct = req_cur.stall_pct;
          in_tvalid <= 1'b1;
          in_tuser  <= req_cur.cmd;
          in_tdata  <= {{(IN_W - 2 * CW - TW){1'b0}}, req_cur.pt, req_cur.py, req_cur.px};
        end else begin
          in_tvalid <= 1'b0;
          in_tuser  <= 1'($urandom_range(1));
          in_tdata  <= IN_W'({$urandom, $urandom});
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expected point, stall at random
  always @(posedge clk) begin
    curve_pt_t exp_pt;
    logic [OW-1:0] got_x;
    logic [OW-1:0] got_y;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_x = out_tdata[OW-1:0];
        got_y = out_tdata[2*OW-1:OW];
        if (curve_expected.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got x=%0d y=%0d", $time, got_x, got_y);
        end else begin
          exp_pt = curve_expected.pop_front();
          if (got_x !== exp_pt.cx) begin
            mismatches++;
            $display("%0t: curve_x expected %0d got %0d", $time, exp_pt.cx, got_x);
          end
          if (got_y !== exp_pt.cy) begin
            mismatches++;
            $display("%0t: curve_y expected %0d got %0d", $time, exp_pt.cy, got_y);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 69, 0, 28};
    stall_tab = '{0, 0, 69, 28};

    // Directed: empty window, partial fill, extremes of t and coordinates
    add_eval(int'(T_ONE / 2));
    add_push(0, 0);
    add_eval(0);
    add_push(CMAX, CMAX);
    add_push(0, CMAX);
    add_eval(int'(T_ONE));
    add_push(CMAX, 0);
    add_eval(0);
    add_eval(int'(T_ONE));
    add_eval(TMAX);
    add_eval(int'(T_ONE) + 1);
    add_eval(int'(T_ONE / 2));
    add_eval(1);
    repeat (4) add_push(CMAX, CMAX);
    add_eval(int'(T_ONE / 2));
    add_eval(0);
    repeat (4) add_push(0, 0);
    add_eval(int'(T_ONE / 3));

    // Random traffic in four pressure phases
    for (int ph = 0; ph < 4; ph++) begin
      ph_idle  = idle_tab[ph];
      ph_stall = stall_tab[ph];
      for (int k = 0; k < 490; k++) begin
        if ($urandom_range(99) < 40) add_push(rand_coord(), rand_coord());
        else add_eval(rand_t());
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (req_taken < req_total) @(posedge clk);
    while (curve_expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> cubic_bspline_point_eval.f
rtl/core/cbsp_pkg.sv
rtl/core/cbsp_ctrl.sv
rtl/core/cbsp_lane.sv
rtl/core/cbsp_datapath.sv
rtl/core/cubic_bspline_point_eval.sv
tb/tb_top.sv
